[hdl/plc_pkg.sv]
package plc_pkg;

  // default sizing
  localparam int CURVES_DEF  = 8;
  localparam int ENTRIES_DEF = 64;

  // fixed field widths
  localparam int CURVE_W = 3;
  localparam int INDEX_W = 6;
  localparam int DATA_W  = 16;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;

  // op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

  // one table word: segment start, slope, offset (all Q7.8)
  typedef struct packed {
    logic signed [DATA_W-1:0] bp;
    logic signed [DATA_W-1:0] slope;
    logic signed [DATA_W-1:0] offset;
  } plc_entry_t;

  // sequencer -> multiply-add unit
  typedef struct packed {
    logic              mul;           // product from read slope and voltage
    logic              fin;           // add offset, clamp, present result
    logic              fixed;         // present a constant result (load / empty)
    logic [STAT_W-1:0] fixed_status;
  } plc_mac_ctl_t;

endpackage

[hdl/plc_mem.sv]
module plc_mem
  import plc_pkg::*;
#(
  parameter int DEPTH = CURVES_DEF * ENTRIES_DEF,
  parameter int AW    = $clog2(CURVES_DEF * ENTRIES_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  plc_entry_t       wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output plc_entry_t       rdata
);

  plc_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/plc_mac.sv]
module plc_mac
  import plc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  plc_mac_ctl_t              ctl,
  input  logic signed [DATA_W-1:0]  slope_rd,
  input  logic signed [DATA_W-1:0]  offset_rd,
  input  logic signed [DATA_W-1:0]  volt,
  output logic signed [VALUE_W-1:0] value,
  output logic [STAT_W-1:0]         status,
  output logic                      done
);

  localparam logic signed [VALUE_W:0] SAT_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [VALUE_W:0] SAT_MIN = 33'sh1_8000_0000;

  logic signed [2*DATA_W-1:0] prod;
  logic signed [DATA_W-1:0]   offset;
  logic signed [VALUE_W:0]    sum;

  // offset moves from Q7.8 to Q15.16 alignment
  assign sum = (VALUE_W+1)'(prod)
             + $signed({{(VALUE_W+1-DATA_W-8){offset[DATA_W-1]}}, offset, 8'd0});

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod   <= slope_rd * volt;
      offset <= offset_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.fin | ctl.fixed;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fixed) begin
      value  <= '0;
      status <= ctl.fixed_status;
    end else if (ctl.fin) begin
      if (sum > SAT_MAX) begin
        value  <= SAT_MAX[VALUE_W-1:0];
        status <= ST_SAT;
      end else if (sum < SAT_MIN) begin
        value  <= SAT_MIN[VALUE_W-1:0];
        status <= ST_SAT;
      end else begin
        value  <= sum[VALUE_W-1:0];
        status <= ST_OK;
      end
    end
  end

endmodule

[hdl/plc_ctrl.sv]
module plc_ctrl
  import plc_pkg::*;
#(
  parameter int CURVES  = CURVES_DEF,
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int AW      = $clog2(CURVES_DEF * ENTRIES_DEF)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op,
  input  logic [CURVE_W-1:0]       curve,
  input  logic [INDEX_W-1:0]       entry_index,
  input  logic signed [DATA_W-1:0] voltage,
  input  logic signed [DATA_W-1:0] bp_rd,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  output logic signed [DATA_W-1:0] volt,
  output plc_mac_ctl_t             mac_ctl
);

  localparam int CW   = (CURVES > 1) ? $clog2(CURVES) : 1;
  localparam int IW   = $clog2(ENTRIES);
  localparam int CNTW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;

  logic [2:0]    state, state_next;
  logic [CNTW-1:0] entry_count [CURVES];
  logic [IW-1:0] lo, hi, mid;
  logic [IW-1:0] mid_next;
  logic [IW:0]   lo_hi_sum;
  logic [AW-1:0] base;

  logic          accept;
  logic          curve_ok, index_ok;
  logic [CW-1:0] curve_idx;
  logic [AW-1:0] accept_base;
  logic          eval_empty;

  assign accept      = start & ~busy;
  assign busy        = (state != S_IDLE);
  assign curve_ok    = (32'(curve) < CURVES);
  assign index_ok    = (32'(entry_index) < ENTRIES);
  assign curve_idx   = CW'(curve);
  assign accept_base = AW'(AW'(curve_idx) * AW'(ENTRIES));
  assign eval_empty  = ~curve_ok || (entry_count[curve_idx] == '0);

  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_next  = lo_hi_sum[IW:1] + IW'(1);

  // table write happens in the accept cycle of a load
  assign mem_we    = accept && (op == OP_LOAD) && curve_ok && index_ok;
  assign mem_waddr = accept_base + AW'(IW'(entry_index));

  assign mem_re    = (state == S_PROBE);
  assign mem_raddr = (lo < hi) ? (base + AW'(mid_next)) : (base + AW'(lo));

  always_comb begin
    mac_ctl              = '0;
    mac_ctl.fixed_status = ST_OK;
    if (accept && ((op == OP_LOAD) || eval_empty)) begin
      mac_ctl.fixed = 1'b1;
      if (op == OP_EVAL) begin
        mac_ctl.fixed_status = ST_EMPTY;
      end
    end
    mac_ctl.mul = (state == S_MUL);
    mac_ctl.fin = (state == S_ADD);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (op == OP_EVAL) && !eval_empty) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: state_next = (lo < hi) ? S_CMP : S_MUL;
      S_CMP:   state_next = S_PROBE;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < CURVES; i++) begin
        entry_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (mem_we) begin
        entry_count[curve_idx] <= CNTW'({1'b0, entry_index} + 7'd1);
      end
    end
  end

  // search bounds, latched voltage and curve base
  always_ff @(posedge clk) begin
    if (accept) begin
      volt <= voltage;
      base <= accept_base;
      lo   <= '0;
      hi   <= IW'(entry_count[curve_idx] - CNTW'(1));
    end else if (state == S_PROBE) begin
      mid <= mid_next;
    end else if (state == S_CMP) begin
      if (volt < bp_rd) begin
        hi <= mid - IW'(1);
      end else begin
        lo <= mid;
      end
    end
  end

endmodule

[hdl/piecewise_linear_curve_lookup_top.sv]
// Piecewise-linear curve lookup. Holds CURVES curves of up to ENTRIES segments,
// each segment a Q7.8 breakpoint, slope and offset. Pulse start while busy is
// low to issue one beat: op=0 loads one entry of a curve (and sets that curve's
// entry count to entry_index+1), op=1 evaluates a curve at voltage. Every beat
// yields exactly one result beat, shown on value/status for a single cycle
// with done high; the receiver cannot stall, so capture it on that cycle.
// Loads and evaluations of an empty or out-of-range curve answer the next
// cycle and never raise busy, so they can be issued back to back. An
// evaluation runs a binary search over the curve's breakpoints through one
// table read port (each probe a table read and then a compare, at most
// ceil(log2(count)) probes), then one segment fetch, one multiply and one
// add/clamp, with done high in the cycle that busy is low again.
// The tables are not cleared at reset; only entry counts are.
module piecewise_linear_curve_lookup_top
  import plc_pkg::*;
#(
  parameter int CURVES  = CURVES_DEF,
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      op,
  input  logic [CURVE_W-1:0]        curve,
  input  logic [INDEX_W-1:0]        entry_index,
  input  logic signed [DATA_W-1:0]  breakpoint,
  input  logic signed [DATA_W-1:0]  slope,
  input  logic signed [DATA_W-1:0]  offset,
  input  logic signed [DATA_W-1:0]  voltage,
  output logic signed [VALUE_W-1:0] value,
  output logic [STAT_W-1:0]         status,
  output logic                      done
);

  localparam int DEPTH = CURVES * ENTRIES;
  localparam int AW    = $clog2(DEPTH);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  plc_entry_t               wdata;
  plc_entry_t               rdata;
  logic signed [DATA_W-1:0] volt;
  plc_mac_ctl_t             mac_ctl;

  assign wdata.bp     = breakpoint;
  assign wdata.slope  = slope;
  assign wdata.offset = offset;

  // sequencer: entry counts, search bounds, table addressing
  plc_ctrl #(
    .CURVES  (CURVES),
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .curve       (curve),
    .entry_index (entry_index),
    .voltage     (voltage),
    .bp_rd       (rdata.bp),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .volt        (volt),
    .mac_ctl     (mac_ctl)
  );

  // segment tables, one word per entry, registered read
  plc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // slope*voltage + offset, clamp, result register
  plc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .slope_rd  (rdata.slope),
    .offset_rd (rdata.offset),
    .volt      (volt),
    .value     (value),
    .status    (status),
    .done      (done)
  );

endmodule

[verif/tb.sv]
module tb;
  import plc_pkg::*;

  localparam int NCURVE       = CURVES_DEF;
  localparam int NENTRY       = ENTRIES_DEF;
  localparam int RANDOM_BEATS = 1850;
  localparam int QUIET_TAIL   = 200;     // last beats of the run go without idling
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;

  // One command beat plus, for directed rows, a typed-in expectation.
  typedef struct packed {
    logic                     op;
    logic [CURVE_W-1:0]       curve;
    logic [INDEX_W-1:0]       idx;
    logic signed [DATA_W-1:0] bp;
    logic signed [DATA_W-1:0] sl;
    logic signed [DATA_W-1:0] ofs;
    logic signed [DATA_W-1:0] volt;
    logic                     typed;
    logic signed [VALUE_W-1:0] exp_value;
    logic [STAT_W-1:0]        exp_status;
  } beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STAT_W-1:0]         status;
  } curve_result_t;

  localparam int NDIR = 25;

  // Directed beats. Loads, empty curves and the plain extreme products are typed
  // in; the remaining rows (typed = 0) go through the predictor.
  localparam beat_t DIRECTED [NDIR] = '{
    // empty curves straight out of reset
    '{OP_EVAL, 3'd0, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h0, ST_EMPTY},
    '{OP_EVAL, 3'd7, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 1'b1, 32'h0, ST_EMPTY},
    // one segment with extreme slope and offset
    '{OP_LOAD, 3'd0, 6'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_EVAL, 3'd0, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0, 32'h0, ST_OK},
    '{OP_EVAL, 3'd0, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 1'b0, 32'h0, ST_OK},
    // most negative slope: largest positive product
    '{OP_LOAD, 3'd1, 6'd0, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_EVAL, 3'd1, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1, 32'h40000000, ST_OK},
    '{OP_EVAL, 3'd1, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 1'b0, 32'h0, ST_OK},
    // flat segment, most negative offset
    '{OP_LOAD, 3'd1, 6'd0, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_EVAL, 3'd1, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'hff800000, ST_OK},
    // three ascending segments: below all, on a breakpoint, between, top
    '{OP_LOAD, 3'd2, 6'd0, 16'hff00, 16'h0100, 16'h0000, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_LOAD, 3'd2, 6'd1, 16'h0000, 16'h0200, 16'h0080, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_LOAD, 3'd2, 6'd2, 16'h0100, 16'hfe00, 16'h0400, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_EVAL, 3'd2, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0, 32'h0, ST_OK},
    '{OP_EVAL, 3'd2, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'h0, ST_OK},
    '{OP_EVAL, 3'd2, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h00ff, 1'b0, 32'h0, ST_OK},
    '{OP_EVAL, 3'd2, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 1'b0, 32'h0, ST_OK},
    // breakpoints out of order: the probe sequence still fixes the segment
    '{OP_LOAD, 3'd3, 6'd0, 16'h0500, 16'h0100, 16'h0000, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_LOAD, 3'd3, 6'd1, 16'hfb00, 16'hff00, 16'h0100, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_LOAD, 3'd3, 6'd2, 16'h0000, 16'h0300, 16'hff00, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_EVAL, 3'd3, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0200, 1'b0, 32'h0, ST_OK},
    '{OP_EVAL, 3'd3, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'hfc00, 1'b0, 32'h0, ST_OK},
    // top index, then shrink the curve back to one written entry
    '{OP_LOAD, 3'd4, 6'd63, 16'h5555, 16'haaaa, 16'h5555, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_LOAD, 3'd4, 6'd0, 16'haaaa, 16'h5555, 16'haaaa, 16'h0000, 1'b1, 32'h0, ST_OK},
    '{OP_EVAL, 3'd4, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h5555, 1'b0, 32'h0, ST_OK}
  };

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      op;
  logic [CURVE_W-1:0]        curve;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [DATA_W-1:0]  breakpoint;
  logic signed [DATA_W-1:0]  slope;
  logic signed [DATA_W-1:0]  offset;
  logic signed [DATA_W-1:0]  voltage;
  logic signed [VALUE_W-1:0] value;
  logic [STAT_W-1:0]         status;
  logic                      done;

  // typed-in expectation that travels with the beat on the command lines
  logic                      use_typed;
  logic signed [VALUE_W-1:0] typed_value;
  logic [STAT_W-1:0]         typed_status;

  piecewise_linear_curve_lookup_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .curve       (curve),
    .entry_index (entry_index),
    .breakpoint  (breakpoint),
    .slope       (slope),
    .offset      (offset),
    .voltage     (voltage),
    .value       (value),
    .status      (status),
    .done        (done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the segment tables and entry counts.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] seg_bp    [NCURVE][NENTRY];
  logic signed [DATA_W-1:0] seg_slope [NCURVE][NENTRY];
  logic signed [DATA_W-1:0] seg_ofs   [NCURVE][NENTRY];
  int                       seg_count [NCURVE];

  curve_result_t pending_results [$];
  int            mismatches;
  int            cycle_count;

  // Applies one beat to the predictor and returns the result it should give.
  task automatic curve_lookup(input logic op_i, input logic [CURVE_W-1:0] c,
                              input logic [INDEX_W-1:0] idx,
                              input logic signed [DATA_W-1:0] bp_i,
                              input logic signed [DATA_W-1:0] sl_i,
                              input logic signed [DATA_W-1:0] ofs_i,
                              input logic signed [DATA_W-1:0] v_i,
                              output curve_result_t res);
    int     lo;
    int     hi;
    int     mid;
    longint acc;
    res.value  = '0;
    res.status = ST_OK;
    if (op_i == OP_LOAD) begin
      if (c < NCURVE && idx < NENTRY) begin
        seg_bp[c][idx]    = bp_i;
        seg_slope[c][idx] = sl_i;
        seg_ofs[c][idx]   = ofs_i;
        seg_count[c]      = idx + 1;
      end
    end else if (c >= NCURVE || seg_count[c] == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // last breakpoint not above the voltage, segment 0 if below all
      lo = 0;
      hi = seg_count[c] - 1;
      while (lo < hi) begin
        mid = (lo + hi) / 2 + 1;
        if (v_i < seg_bp[c][mid]) hi = mid - 1;
        else lo = mid;
      end
      acc = longint'(seg_slope[c][lo]) * longint'(v_i) + longint'(seg_ofs[c][lo]) * 256;
      if (acc > 64'sd2147483647) begin
        acc        = 64'sd2147483647;
        res.status = ST_SAT;
      end else if (acc < -64'sd2147483648) begin
        acc        = -64'sd2147483648;
        res.status = ST_SAT;
      end
      res.value = acc[VALUE_W-1:0];
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, so the values seen
  // here are the ones the DUT registers at that same edge.
  //  - done high: one result beat, compared with the oldest expectation
  //  - start high, busy low: a command beat is taken; predict and queue it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    curve_result_t got_exp;
    curve_result_t predicted;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, value %0d status %0d",
                   $time, value, status);
          mismatches++;
        end else begin
          got_exp = pending_results.pop_front();
          if (value !== got_exp.value) begin
            $display("%0t: value mismatch, expected %0d actual %0d",
                     $time, got_exp.value, value);
            mismatches++;
          end
          if (status !== got_exp.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, got_exp.status, status);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        curve_lookup(op, curve, entry_index, breakpoint, slope, offset, voltage, predicted);
        if (use_typed) begin
          predicted.value  = typed_value;
          predicted.status = typed_status;
        end
        pending_results.insert(pending_results.size(), predicted);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus side bookkeeping: which table entries have been written, so that
  // no evaluation ever reads an entry the DUT holds uninitialized.
  // ---------------------------------------------------------------------------
  bit                       gen_written [NCURVE][NENTRY];
  int                       gen_len     [NCURVE];
  logic signed [DATA_W-1:0] gen_bp      [NCURVE][NENTRY];
  int                       issued;
  bit                       idle_on;

  function automatic bit curve_ready(int c);
    for (int i = 0; i < gen_len[c]; i++)
      if (!gen_written[c][i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    b.op         = 1'($urandom_range(0, 1));
    b.curve      = CURVE_W'($urandom_range(0, NCURVE - 1));
    b.idx        = INDEX_W'($urandom_range(0, NENTRY - 1));
    b.bp         = 16'($urandom);
    b.sl         = 16'($urandom);
    b.ofs        = 16'($urandom);
    b.volt       = 16'($urandom);
    b.typed      = 1'b0;
    b.exp_value  = '0;
    b.exp_status = ST_OK;
    return b;
  endfunction

  // Drive one command beat and hold it until it is taken. start stays high
  // into the next beat unless an idle burst follows.
  task automatic issue(input beat_t b);
    op           <= b.op;
    curve        <= b.curve;
    entry_index  <= b.idx;
    breakpoint   <= b.bp;
    slope        <= b.sl;
    offset       <= b.ofs;
    voltage      <= b.volt;
    use_typed    <= b.typed;
    typed_value  <= b.exp_value;
    typed_status <= b.exp_status;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (b.op == OP_LOAD) begin
      gen_written[b.curve][b.idx] = 1'b1;
      gen_bp[b.curve][b.idx]      = b.bp;
      gen_len[b.curve]            = b.idx + 1;
    end
    issued++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Evaluations on curve c (or the next curve that is safe to read),
  // voltages either anywhere or right around one of the breakpoints.
  task automatic eval_some(input int c, input int k);
    int    cc;
    int    vv;
    beat_t b;
    for (int j = 0; j < k; j++) begin
      cc = c;
      for (int n = 0; n < NCURVE && !curve_ready(cc); n++) cc = (cc + 1) % NCURVE;
      if (curve_ready(cc)) begin
        b       = rand_beat();
        b.op    = OP_EVAL;
        b.curve = CURVE_W'(cc);
        if (gen_len[cc] > 0 && $urandom_range(0, 1) == 1) begin
          vv = int'(gen_bp[cc][$urandom_range(0, gen_len[cc] - 1)]);
          vv = vv + int'($urandom_range(0, 2)) - 1;
          if (vv > 32767) vv = 32767;
          if (vv < -32768) vv = -32768;
          b.volt = 16'(vv);
        end
        issue(b);
      end
    end
  endtask

  // Load entries 0..n-1 of curve c: spread ascending, clustered (with equal
  // neighbors) or in no order at all.
  task automatic build_curve(input int c, input int n);
    int    style;
    int    step;
    int    acc;
    beat_t b;
    style = $urandom_range(0, 5);
    step  = 65536 / n;
    acc   = int'($urandom_range(0, 65535 - 3 * n)) - 32768;
    for (int i = 0; i < n; i++) begin
      b       = rand_beat();
      b.op    = OP_LOAD;
      b.curve = CURVE_W'(c);
      b.idx   = INDEX_W'(i);
      if (style < 4) begin
        b.bp = 16'(-32768 + i * step + int'($urandom_range(0, step - 1)));
      end else if (style == 4) begin
        b.bp = 16'(acc);
        acc  = acc + int'($urandom_range(0, 3));
      end
      issue(b);
    end
  endtask

  initial begin
    int    c;
    int    n;
    int    sel;
    beat_t b;
    rst          = 1'b1;
    start        = 1'b0;
    op           = OP_LOAD;
    curve        = '0;
    entry_index  = '0;
    breakpoint   = '0;
    slope        = '0;
    offset       = '0;
    voltage      = '0;
    use_typed    = 1'b0;
    typed_value  = '0;
    typed_status = ST_OK;
    mismatches   = 0;
    cycle_count  = 0;
    issued       = 0;
    idle_on      = 1'b1;
    for (int i = 0; i < NCURVE; i++) seg_count[i] = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NDIR; i++) issue(DIRECTED[i]);

    // Random part: mostly freshly built curves followed by evaluations,
    // the rest rewrites, stray loads and lone evaluations.
    while (issued < NDIR + RANDOM_BEATS) begin
      idle_on = (issued < NDIR + RANDOM_BEATS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
      c   = $urandom_range(0, NCURVE - 1);
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        n = $urandom_range(0, 15);
        if (n == 0) n = NENTRY;                      // a full curve now and then
        else if (n < 3) n = $urandom_range(9, NENTRY - 1);
        else n = $urandom_range(1, 8);
        build_curve(c, n);
        eval_some(c, $urandom_range(1, 12));
      end else if (sel < 7) begin
        eval_some(c, $urandom_range(1, 6));
      end else if (sel == 7) begin
        // overwrite an entry inside the curve; this shortens it unless it is the last entry
        if (gen_len[c] > 0) begin
          b       = rand_beat();
          b.op    = OP_LOAD;
          b.curve = CURVE_W'(c);
          b.idx   = INDEX_W'($urandom_range(0, gen_len[c] - 1));
          issue(b);
        end
        eval_some(c, $urandom_range(1, 4));
      end else if (sel == 8) begin
        // stray load anywhere; may leave the curve unsafe to read until rebuilt
        b    = rand_beat();
        b.op = OP_LOAD;
        issue(b);
      end else begin
        eval_some(c, 1);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/plc_pkg.sv
hdl/plc_mem.sv
hdl/plc_mac.sv
hdl/plc_ctrl.sv
hdl/piecewise_linear_curve_lookup_top.sv
verif/tb.sv
